[src/cpg_pkg.sv]
// shared types, sizes and codes of the contact patch grouper
`default_nettype none

package cpg_pkg;

    // patch buffer capacity and the counter width that can hold it
    localparam int MAX_PATCHES = 64;
    localparam int CNT_W       = $clog2(MAX_PATCHES + 1);

    // classified contact queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // result queue at the output side of the back end
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // batch index and run length saturate at 127
    localparam int               IDX_W   = 7;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;
    localparam int               RUN_W   = 7;
    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    localparam logic signed [15:0] TOL_RESET = 16'sd16367;

    localparam logic STATUS_PATCH    = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [31:0]        static_friction;
        logic [31:0]        dynamic_friction;
        logic [31:0]        restitution;
        logic [7:0]         material_flags;
        logic               last_in_batch;
        logic               restart_buffer;
    } t_cpg_contact;

    typedef struct packed {
        logic [5:0]         patch_slot;
        logic [5:0]         start_index;
        logic [6:0]         contact_count;
        logic signed [31:0] bound_min_x;
        logic signed [31:0] bound_min_y;
        logic signed [31:0] bound_min_z;
        logic signed [31:0] bound_max_x;
        logic signed [31:0] bound_max_y;
        logic signed [31:0] bound_max_z;
        logic               status;
        logic               batch_done;
    } t_cpg_result;

    // contact after classification by the front end
    typedef struct packed {
        logic [2:0][31:0] point;
        logic [2:0][15:0] normal;
        logic [31:0]      sfric;
        logic [31:0]      dfric;
        logic [31:0]      restit;
        logic             last;
        logic             restart;
        logic             first;
        logic [5:0]       start_idx;
    } t_cpg_entry;

endpackage

`default_nettype wire

[src/cpg_front.sv]
// front end: accepts contact beats and tags each with its place in the batch
`default_nettype none

module cpg_front import cpg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_cpg_contact i_in_beat,
    output logic         o_in_stall,
    input  logic         i_q_full,
    output logic         o_push,
    output t_cpg_entry   o_entry
);

    logic [IDX_W-1:0] r_index;
    logic [IDX_W-1:0] n_index;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        n_index = r_index;
        if (o_push) begin
            if (i_in_beat.last_in_batch) begin
                n_index = '0;
            end else if (r_index != IDX_MAX) begin
                n_index = IDX_W'(r_index + 1'b1);
            end
        end
    end

    always_comb begin
        o_entry.point[0]  = i_in_beat.point_x;
        o_entry.point[1]  = i_in_beat.point_y;
        o_entry.point[2]  = i_in_beat.point_z;
        o_entry.normal[0] = i_in_beat.normal_x;
        o_entry.normal[1] = i_in_beat.normal_y;
        o_entry.normal[2] = i_in_beat.normal_z;
        o_entry.sfric     = i_in_beat.static_friction;
        o_entry.dfric     = i_in_beat.dynamic_friction;
        o_entry.restit    = i_in_beat.restitution;
        o_entry.last      = i_in_beat.last_in_batch;
        o_entry.restart   = i_in_beat.restart_buffer;
        o_entry.first     = (r_index == '0);
        o_entry.start_idx = r_index[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

endmodule

`default_nettype wire

[src/cpg_queue.sv]
// small fifo of classified contacts between front and back
`default_nettype none

module cpg_queue import cpg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cpg_entry i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_cpg_entry o_data
);

    t_cpg_entry       r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_head;
    logic [Q_AW-1:0]  r_tail;
    logic [Q_CW-1:0]  r_count;
    logic [Q_CW-1:0]  n_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = Q_CW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = Q_CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_tail <= Q_AW'(r_tail + 1'b1);
            end
            if (i_pop) begin
                r_head <= Q_AW'(r_head + 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

[src/cpg_back.sv]
// back end: patch grouping, buffer accounting and the result fifo
`default_nettype none

module cpg_back import cpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_data,
    input  logic               i_q_valid,
    input  t_cpg_entry         i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    output t_cpg_result        o_out_beat,
    input  logic               i_out_stall
);

    logic signed [15:0] r_tol;
    logic [CNT_W-1:0]   r_committed, n_committed;
    logic [CNT_W-1:0]   r_working,   n_working;
    logic               r_failed,    n_failed;
    logic [5:0]         r_run_start, n_run_start;
    logic [RUN_W-1:0]   r_run_len,   n_run_len;
    logic [2:0][15:0]   r_ref_n,     n_ref_n;
    logic [31:0]        r_ref_sf,    n_ref_sf;
    logic [31:0]        r_ref_df,    n_ref_df;
    logic [31:0]        r_ref_rs,    n_ref_rs;
    logic [2:0][31:0]   r_min,       n_min;
    logic [2:0][31:0]   r_max,       n_max;

    t_cpg_result        r_omem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_ohead;
    logic [OQ_AW-1:0]   r_otail;
    logic [OQ_CW-1:0]   r_ocount;
    logic [OQ_CW-1:0]   n_ocount;

    logic               push0, push1;
    t_cpg_result        res0, res1, res_fin;
    logic               out_pop;
    logic [CNT_W-1:0]   c_base;
    logic signed [31:0] prod [3];
    logic signed [33:0] dot;
    logic signed [33:0] tol_q;
    logic               joins;

    function automatic t_cpg_result make_patch(
        input logic [CNT_W-1:0] working,
        input logic [5:0]       start,
        input logic [RUN_W-1:0] len,
        input logic [2:0][31:0] mn,
        input logic [2:0][31:0] mx,
        input logic             done
    );
        t_cpg_result r;
        r.patch_slot    = 6'(CNT_W'(working - 1'b1));
        r.start_index   = start;
        r.contact_count = 7'(len);
        r.bound_min_x   = mn[0];
        r.bound_min_y   = mn[1];
        r.bound_min_z   = mn[2];
        r.bound_max_x   = mx[0];
        r.bound_max_y   = mx[1];
        r.bound_max_z   = mx[2];
        r.status        = STATUS_PATCH;
        r.batch_done    = done;
        return r;
    endfunction

    function automatic t_cpg_result make_overflow();
        t_cpg_result r;
        r            = '0;
        r.status     = STATUS_OVERFLOW;
        r.batch_done = 1'b1;
        return r;
    endfunction

    // room for two results before taking a contact
    assign o_pop       = i_q_valid && (r_ocount <= OQ_CW'(OQ_DEPTH - 2));
    assign o_out_valid = (r_ocount != '0);
    assign o_out_beat  = r_omem[r_ohead];
    assign out_pop     = o_out_valid && !i_out_stall;

    // normal dot product against the patch's first normal, Q6.28
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = $signed(i_q_data.normal[i]) * $signed(r_ref_n[i]);
        end
        dot   = 34'(prod[0]) + 34'(prod[1]) + 34'(prod[2]);
        tol_q = {{4{r_tol[15]}}, r_tol, 14'b0};
        joins = (i_q_data.sfric == r_ref_sf) && (i_q_data.dfric == r_ref_df)
             && (i_q_data.restit == r_ref_rs) && (dot >= tol_q);
    end

    always_comb begin
        n_committed = r_committed;
        n_working   = r_working;
        n_failed    = r_failed;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_ref_n     = r_ref_n;
        n_ref_sf    = r_ref_sf;
        n_ref_df    = r_ref_df;
        n_ref_rs    = r_ref_rs;
        n_min       = r_min;
        n_max       = r_max;
        push0       = 1'b0;
        push1       = 1'b0;
        res0        = '0;
        res1        = '0;
        res_fin     = '0;
        c_base      = i_q_data.restart ? '0 : r_committed;

        if (o_pop) begin
            n_committed = c_base;
            if (r_failed) begin
                // dropping the rest of a failed batch
                if (i_q_data.last) begin
                    n_failed = 1'b0;
                end
            end else if ((i_q_data.first && c_base >= CNT_W'(MAX_PATCHES))
                      || (!i_q_data.first && !joins
                          && r_working >= CNT_W'(MAX_PATCHES))) begin
                push0    = 1'b1;
                res0     = make_overflow();
                n_failed = !i_q_data.last;
            end else begin
                if (i_q_data.first || !joins) begin
                    if (!i_q_data.first) begin
                        // close the open patch
                        push0 = 1'b1;
                        res0  = make_patch(r_working, r_run_start, r_run_len,
                                           r_min, r_max, 1'b0);
                    end
                    n_working   = i_q_data.first ? CNT_W'(c_base + 1'b1)
                                                 : CNT_W'(r_working + 1'b1);
                    n_run_start = i_q_data.start_idx;
                    n_run_len   = RUN_W'(1);
                    n_ref_n     = i_q_data.normal;
                    n_ref_sf    = i_q_data.sfric;
                    n_ref_df    = i_q_data.dfric;
                    n_ref_rs    = i_q_data.restit;
                    n_min       = i_q_data.point;
                    n_max       = i_q_data.point;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if ($signed(i_q_data.point[i]) < $signed(r_min[i])) begin
                            n_min[i] = i_q_data.point[i];
                        end
                        if ($signed(i_q_data.point[i]) > $signed(r_max[i])) begin
                            n_max[i] = i_q_data.point[i];
                        end
                    end
                    if (r_run_len != RUN_MAX) begin
                        n_run_len = RUN_W'(r_run_len + 1'b1);
                    end
                end
                if (i_q_data.last) begin
                    res_fin     = make_patch(n_working, n_run_start, n_run_len,
                                             n_min, n_max, 1'b1);
                    n_committed = n_working;
                    if (push0) begin
                        push1 = 1'b1;
                        res1  = res_fin;
                    end else begin
                        push0 = 1'b1;
                        res0  = res_fin;
                    end
                end
            end
        end
    end

    always_comb begin
        n_ocount = OQ_CW'(r_ocount + OQ_CW'(push0) + OQ_CW'(push1) - OQ_CW'(out_pop));
    end

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_omem[r_otail] <= res0;
        end
        if (push1) begin
            r_omem[OQ_AW'(r_otail + 1'b1)] <= res1;
        end
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        r_ref_n     <= n_ref_n;
        r_ref_sf    <= n_ref_sf;
        r_ref_df    <= n_ref_df;
        r_ref_rs    <= n_ref_rs;
        r_min       <= n_min;
        r_max       <= n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_committed <= '0;
            r_working   <= '0;
            r_failed    <= 1'b0;
            r_ohead     <= '0;
            r_otail     <= '0;
            r_ocount    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            r_committed <= n_committed;
            r_working   <= n_working;
            r_failed    <= n_failed;
            r_ocount    <= n_ocount;
            r_otail     <= OQ_AW'(r_otail + OQ_AW'(push0) + OQ_AW'(push1));
            if (out_pop) begin
                r_ohead <= OQ_AW'(r_ohead + 1'b1);
            end
        end
    end

    a_overflow_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push0 && res0.status == STATUS_OVERFLOW) |-> (res0.batch_done && !push1))
        else $error("overflow result not alone or not marked batch end");

    a_counts_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_working <= CNT_W'(MAX_PATCHES)) && (r_committed <= CNT_W'(MAX_PATCHES)))
        else $error("patch counter beyond buffer capacity");

    a_result_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= OQ_CW'(OQ_DEPTH))
        else $error("result fifo overrun");

    a_failed_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && o_pop) |-> !push0)
        else $error("result produced while dropping a failed batch");

    a_fail_follows_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_failed) |-> $past(push0 && res0.status == STATUS_OVERFLOW))
        else $error("batch failure without an overflow result");

endmodule

`default_nettype wire

[src/contact_patch_grouper.sv]
// top level of the contact patch grouper
//
//  channel  dir  handshake                    beat
//  in       rx   i_in_valid / o_in_stall      t_cpg_contact, one contact
//  out      tx   o_out_valid / i_out_stall    t_cpg_result, one patch or overflow
//  cfg      rx   i_cfg_we                     i_cfg_data, normal tolerance Q2.14
//
// a contact can be taken every cycle while the contact queue is not full; each
// result passes the queue register, then the result fifo register
// the output port moves one result per cycle while not stalled, so contacts that
// close a patch and end the batch (two results) take output bandwidth for both
// reset is synchronous, active low; it clears counters and queues and sets the
// tolerance to 16367, no clearing pass
// an output stall reaches the input only once the result fifo and the contact
// queue fill: they decouple the front end from the grouping logic and the output
`default_nettype none

module contact_patch_grouper import cpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // contact input
    input  logic               i_in_valid,
    input  t_cpg_contact       i_in_beat,
    output logic               o_in_stall,
    // patch results
    output logic               o_out_valid,
    output t_cpg_result        o_out_beat,
    input  logic               i_out_stall,
    // tolerance register
    input  logic               i_cfg_we,
    input  logic signed [15:0] i_cfg_data
);

    // front to queue
    logic       front_push;
    t_cpg_entry front_entry;
    logic       q_full;

    // queue to back
    logic       q_valid;
    t_cpg_entry q_data;
    logic       back_pop;

    // front end: takes beats and marks batch start and start index
    cpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (front_push),
        .o_entry    (front_entry)
    );

    // short queue of classified contacts
    cpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_entry),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // back end: join test, bounds, buffer accounting, result fifo
    cpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (back_pop),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
